/* design/mfa_pkg.sv */
// Package for the Mueller-from-amplitudes block.
// Holds matrix dimensions, the row index type and the names of the cross-product terms.
// Depends on nothing.
package mfa_pkg;

  localparam int unsigned NUM_AMPS  = 4;
  localparam int unsigned NUM_ROWS  = 4;
  localparam int unsigned NUM_COLS  = 4;
  localparam int unsigned NUM_ELEMS = NUM_ROWS * NUM_COLS;
  localparam int unsigned NUM_PARTS = 12;

  // Real and imaginary parts of the conjugate products that the matrix uses.
  localparam int unsigned PART_23R = 0;
  localparam int unsigned PART_23I = 1;
  localparam int unsigned PART_14R = 2;
  localparam int unsigned PART_14I = 3;
  localparam int unsigned PART_24R = 4;
  localparam int unsigned PART_13R = 5;
  localparam int unsigned PART_13I = 6;
  localparam int unsigned PART_12R = 7;
  localparam int unsigned PART_12I = 8;
  localparam int unsigned PART_34R = 9;
  localparam int unsigned PART_34I = 10;
  localparam int unsigned PART_42I = 11;

  typedef logic [1:0] row_idx_t;

  localparam row_idx_t FIRST_ROW = 2'd0;
  localparam row_idx_t LAST_ROW  = 2'd3;

endpackage

/* design/mfa_if.sv */
// Channel interfaces of the Mueller-from-amplitudes block: amplitudes in, matrix rows out.
// Depends on mfa_pkg.
interface mfa_in_if #(
  parameter int unsigned COMPONENT_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] s1_re;
  logic signed [COMPONENT_BITS-1:0] s1_im;
  logic signed [COMPONENT_BITS-1:0] s2_re;
  logic signed [COMPONENT_BITS-1:0] s2_im;
  logic signed [COMPONENT_BITS-1:0] s3_re;
  logic signed [COMPONENT_BITS-1:0] s3_im;
  logic signed [COMPONENT_BITS-1:0] s4_re;
  logic signed [COMPONENT_BITS-1:0] s4_im;

  modport source (
    output valid, s1_re, s1_im, s2_re, s2_im, s3_re, s3_im, s4_re, s4_im,
    input  ready
  );
  modport sink (
    input  valid, s1_re, s1_im, s2_re, s2_im, s3_re, s3_im, s4_re, s4_im,
    output ready
  );
endinterface

interface mfa_out_if #(
  parameter int unsigned COMPONENT_BITS = 16
);
  localparam int unsigned OutBits = 2 * COMPONENT_BITS + 3;

  logic                      valid;
  logic                      ready;
  mfa_pkg::row_idx_t         row_index;
  logic signed [OutBits-1:0] elem_col0;
  logic signed [OutBits-1:0] elem_col1;
  logic signed [OutBits-1:0] elem_col2;
  logic signed [OutBits-1:0] elem_col3;
  logic                      row_last;

  modport source (
    output valid, row_index, elem_col0, elem_col1, elem_col2, elem_col3, row_last,
    input  ready
  );
  modport sink (
    input  valid, row_index, elem_col0, elem_col1, elem_col2, elem_col3, row_last,
    output ready
  );
endinterface

/* design/mfa_product_stage.sv */
// First pipeline stage: squared magnitudes and conjugate cross products of S1..S4.
// Depends on mfa_pkg.
module mfa_product_stage #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [COMPONENT_BITS-1:0] re_i [mfa_pkg::NUM_AMPS],
  input  logic signed [COMPONENT_BITS-1:0] im_i [mfa_pkg::NUM_AMPS],
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [2*COMPONENT_BITS:0] mag_o [mfa_pkg::NUM_AMPS],
  output logic signed [2*COMPONENT_BITS:0] part_o [mfa_pkg::NUM_PARTS]
);
  import mfa_pkg::*;

  localparam int unsigned PartBits = 2 * COMPONENT_BITS + 1;

  logic signed [PartBits-1:0] re_x [NUM_AMPS];
  logic signed [PartBits-1:0] im_x [NUM_AMPS];
  logic signed [PartBits-1:0] mag_d [NUM_AMPS];
  logic signed [PartBits-1:0] mag_q [NUM_AMPS];
  logic signed [PartBits-1:0] part_d [NUM_PARTS];
  logic signed [PartBits-1:0] part_q [NUM_PARTS];
  logic                       valid_q;
  logic                       load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    for (int k = 0; k < NUM_AMPS; k++) begin
      re_x[k]  = PartBits'(re_i[k]);
      im_x[k]  = PartBits'(im_i[k]);
      mag_d[k] = re_x[k] * re_x[k] + im_x[k] * im_x[k];
    end
    // a * conj(b): real = ar*br + ai*bi, imaginary = ai*br - ar*bi.
    part_d[PART_23R] = re_x[1] * re_x[2] + im_x[1] * im_x[2];
    part_d[PART_23I] = im_x[1] * re_x[2] - re_x[1] * im_x[2];
    part_d[PART_14R] = re_x[0] * re_x[3] + im_x[0] * im_x[3];
    part_d[PART_14I] = im_x[0] * re_x[3] - re_x[0] * im_x[3];
    part_d[PART_24R] = re_x[1] * re_x[3] + im_x[1] * im_x[3];
    part_d[PART_13R] = re_x[0] * re_x[2] + im_x[0] * im_x[2];
    part_d[PART_13I] = im_x[0] * re_x[2] - re_x[0] * im_x[2];
    part_d[PART_12R] = re_x[0] * re_x[1] + im_x[0] * im_x[1];
    part_d[PART_12I] = im_x[0] * re_x[1] - re_x[0] * im_x[1];
    part_d[PART_34R] = re_x[2] * re_x[3] + im_x[2] * im_x[3];
    part_d[PART_34I] = im_x[2] * re_x[3] - re_x[2] * im_x[3];
    part_d[PART_42I] = im_x[3] * re_x[1] - re_x[3] * im_x[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q  <= mag_d;
      part_q <= part_d;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign part_o  = part_q;

endmodule

/* design/mfa_element_stage.sv */
// Second pipeline stage: combines magnitudes and cross products into the sixteen elements.
// Depends on mfa_pkg.
module mfa_element_stage #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [2*COMPONENT_BITS:0]   mag_i [mfa_pkg::NUM_AMPS],
  input  logic signed [2*COMPONENT_BITS:0]   part_i [mfa_pkg::NUM_PARTS],
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [2*COMPONENT_BITS+2:0] elem_o [mfa_pkg::NUM_ELEMS]
);
  import mfa_pkg::*;

  localparam int unsigned OutBits = 2 * COMPONENT_BITS + 3;

  logic signed [OutBits-1:0] a [NUM_AMPS];
  logic signed [OutBits-1:0] p [NUM_PARTS];
  logic signed [OutBits-1:0] elem_d [NUM_ELEMS];
  logic signed [OutBits-1:0] elem_q [NUM_ELEMS];
  logic                      valid_q;
  logic                      load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    for (int k = 0; k < NUM_AMPS; k++) begin
      a[k] = OutBits'(mag_i[k]);
    end
    for (int k = 0; k < NUM_PARTS; k++) begin
      p[k] = OutBits'(part_i[k]);
    end
    // Magnitude sums in the output unit already carry the factor one half.
    elem_d[0]  = a[0] + a[1] + a[2] + a[3];
    elem_d[1]  = a[1] - a[0] + a[3] - a[2];
    elem_d[4]  = a[1] - a[0] - a[3] + a[2];
    elem_d[5]  = a[1] + a[0] - a[3] - a[2];
    // Cross terms are doubled to reach the output unit.
    elem_d[2]  = (p[PART_23R] + p[PART_14R]) <<< 1;
    elem_d[3]  = (p[PART_23I] - p[PART_14I]) <<< 1;
    elem_d[6]  = (p[PART_23R] - p[PART_14R]) <<< 1;
    elem_d[7]  = (p[PART_23I] + p[PART_14I]) <<< 1;
    elem_d[8]  = (p[PART_24R] + p[PART_13R]) <<< 1;
    elem_d[9]  = (p[PART_24R] - p[PART_13R]) <<< 1;
    elem_d[10] = (p[PART_12R] + p[PART_34R]) <<< 1;
    elem_d[11] = (-p[PART_12I] - p[PART_34I]) <<< 1;
    elem_d[12] = (p[PART_42I] + p[PART_13I]) <<< 1;
    elem_d[13] = (p[PART_42I] - p[PART_13I]) <<< 1;
    elem_d[14] = (p[PART_12I] - p[PART_34I]) <<< 1;
    elem_d[15] = (p[PART_12R] - p[PART_34R]) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      elem_q <= elem_d;
    end
  end

  assign valid_o = valid_q;
  assign elem_o  = elem_q;

endmodule

/* design/mfa_row_serializer.sv */
// Output stage: holds one finished matrix and hands it out one row per transfer.
// Depends on mfa_pkg.
module mfa_row_serializer #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [2*COMPONENT_BITS+2:0] elem_i [mfa_pkg::NUM_ELEMS],
  output logic                               valid_o,
  input  logic                               ready_i,
  output mfa_pkg::row_idx_t                  row_index_o,
  output logic signed [2*COMPONENT_BITS+2:0] col_o [mfa_pkg::NUM_COLS],
  output logic                               row_last_o
);
  import mfa_pkg::*;

  localparam int unsigned OutBits = 2 * COMPONENT_BITS + 3;

  logic signed [OutBits-1:0] elem_q [NUM_ELEMS];
  logic                      full_q;
  row_idx_t                  row_q;
  logic                      last_row;
  logic                      row_done;
  logic                      load;

  assign last_row = (row_q == LAST_ROW);
  assign row_done = full_q && ready_i;
  assign ready_o  = !full_q || (ready_i && last_row);
  assign load     = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      row_q  <= FIRST_ROW;
    end else if (load) begin
      full_q <= 1'b1;
      row_q  <= FIRST_ROW;
    end else if (row_done) begin
      if (last_row) begin
        full_q <= 1'b0;
        row_q  <= FIRST_ROW;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      elem_q <= elem_i;
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_COLS; j++) begin
      col_o[j] = elem_q[{row_q, 2'(j)}];
    end
  end

  assign valid_o     = full_q;
  assign row_index_o = row_q;
  assign row_last_o  = last_row;

endmodule

/* design/mueller_from_amplitudes_unit.sv */
// Top level of the Mueller-from-amplitudes block.
// Depends on mfa_pkg, mfa_if, mfa_product_stage, mfa_element_stage and mfa_row_serializer.

// Each input transfer carries the four complex scattering amplitudes S1..S4 of one
// angle, each part a signed fixed-point number with COMPONENT_BITS bits and
// COMPONENT_BITS-1 fraction bits. For every input the block sends exactly four
// output transfers, the rows 0 to 3 of the Mueller matrix in that order, and
// row_last is high on row 3. Elements are exact signed integers in units of
// 2^-(2*COMPONENT_BITS-1), 2^-31 by default, so nothing is rounded or saturated.
// An item passes a product stage (squared magnitudes and conjugate products), an
// element stage (sums and differences) and a row stage that holds the finished
// matrix. The first row is offered once the item has been registered in the product,
// element and row stages in turn. The sustained input rate is set by the row stage,
// which puts out one row per transfer on the single output channel; while it sends
// the rows of one matrix, the next two items move into the stages ahead of it, and a
// new matrix enters the row stage in the same cycle as the last row leaves.
// Backpressure on the output stalls the stages in turn. Reset clears only the
// valid flags and the row counter.
module mueller_from_amplitudes_unit #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mfa_in_if.sink    in_ch_i,
  mfa_out_if.source out_ch_o
);
  import mfa_pkg::*;

  localparam int unsigned PartBits = 2 * COMPONENT_BITS + 1;
  localparam int unsigned OutBits  = 2 * COMPONENT_BITS + 3;

  // Amplitude components gathered into arrays, S1 at index 0.
  logic signed [COMPONENT_BITS-1:0] re [NUM_AMPS];
  logic signed [COMPONENT_BITS-1:0] im [NUM_AMPS];

  // Product stage to element stage.
  logic                       prod_valid;
  logic                       prod_ready;
  logic signed [PartBits-1:0] mag [NUM_AMPS];
  logic signed [PartBits-1:0] part [NUM_PARTS];

  // Element stage to row stage.
  logic                      elem_valid;
  logic                      elem_ready;
  logic signed [OutBits-1:0] elem [NUM_ELEMS];

  // Row stage outputs.
  logic signed [OutBits-1:0] col [NUM_COLS];

  assign re[0] = in_ch_i.s1_re;
  assign im[0] = in_ch_i.s1_im;
  assign re[1] = in_ch_i.s2_re;
  assign im[1] = in_ch_i.s2_im;
  assign re[2] = in_ch_i.s3_re;
  assign im[2] = in_ch_i.s3_im;
  assign re[3] = in_ch_i.s4_re;
  assign im[3] = in_ch_i.s4_im;

  mfa_product_stage #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_product (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_ch_i.valid),
    .ready_o(in_ch_i.ready),
    .re_i   (re),
    .im_i   (im),
    .valid_o(prod_valid),
    .ready_i(prod_ready),
    .mag_o  (mag),
    .part_o (part)
  );

  mfa_element_stage #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_element (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(prod_valid),
    .ready_o(prod_ready),
    .mag_i  (mag),
    .part_i (part),
    .valid_o(elem_valid),
    .ready_i(elem_ready),
    .elem_o (elem)
  );

  // The row stage's counter selects which four stored elements are shown.
  mfa_row_serializer #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_rows (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (elem_valid),
    .ready_o    (elem_ready),
    .elem_i     (elem),
    .valid_o    (out_ch_o.valid),
    .ready_i    (out_ch_o.ready),
    .row_index_o(out_ch_o.row_index),
    .col_o      (col),
    .row_last_o (out_ch_o.row_last)
  );

  assign out_ch_o.elem_col0 = col[0];
  assign out_ch_o.elem_col1 = col[1];
  assign out_ch_o.elem_col2 = col[2];
  assign out_ch_o.elem_col3 = col[3];

endmodule
